FILE: src/rdsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_pkg
// Shared constants and controller/datapath interface types for the radix
// digit string converter.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    // operand and radix sizing
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_RADIX   = 16;
    localparam int RADIX_W     = 5;
    localparam int REM_W       = $clog2(MAX_RADIX);
    localparam int TRIAL_W     = REM_W + 1;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);

    // digit store sizing
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;

    // character constants
    localparam logic [7:0] ZERO_CHAR = 8'h30;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd2;

    // configuration reset values
    localparam logic [RADIX_W-1:0]    RADIX_RST    = 5'd10;
    localparam logic [CFG_DATA_W-1:0] ALPHA_LO_RST = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] ALPHA_HI_RST = 64'h6665646362613938;

    // commands from the controller
    typedef struct packed {
        logic load;       // take a new value, clear digit count
        logic div_step;   // one restoring division bit
        logic store;      // write remainder as next digit
        logic rd_issue;   // read digit store at read address
        logic out_digit;  // load output with looked-up character
        logic out_zero;   // load output with the literal zero char
    } rdsc_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic in_zero;    // incoming value is zero
        logic div_done;   // current step is the last bit of this digit
        logic quot_zero;  // quotient has reached zero
        logic cnt_full;   // digit count has reached the last store slot
        logic addr_zero;  // read address points at least significant digit
        logic out_free;   // output register can take a beat
    } rdsc_sts_t;

endpackage

FILE: src/radix_digit_string_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_string_converter_core
// Converts an unsigned value to its digit characters in a radix of 2 to 16,
// most significant digit first, with the final character marked.
// ----------------------------------------------------------------------------
//  channel   signals                             beat
//  input     in_valid / in_stall, value          one number
//  output    out_valid / out_stall, char_out,    one character
//            last_char
//  config    cfg_we, cfg_index, cfg_data         one register write
//
// For a nonzero value the bit-serial restoring divider works out each digit
// one quotient bit per step and a store state then writes it; readout
// passes through a read state and a load state per character on the
// registered digit store port. A zero value yields a single zero character.
// Reset clears control state and loads the default radix and alphabet.
// A stalled output holds its beat; conversion pauses at readout meanwhile.
// ----------------------------------------------------------------------------
module radix_digit_string_converter_core
    import rdsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [63:0]           value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            char_out,
    output logic                  last_char
);

    rdsc_cmd_t cmd;
    rdsc_sts_t sts;

    // sequencer
    rdsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    rdsc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last_char (last_char),
        .cmd       (cmd),
        .sts       (sts)
    );

    // an output load never overwrites a beat still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_digit || cmd.out_zero) |-> sts.out_free)
        else $error("output loaded while previous beat pending");

    // no division work while the input side is open
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !(cmd.div_step || cmd.store || cmd.rd_issue))
        else $error("conversion activity while idle");

    // a new value is taken only while the input side is open
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (in_valid && !in_stall))
        else $error("value loaded without an input beat");

    // after a zero value is taken, the stored quotient is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && sts.in_zero) |=> sts.quot_zero)
        else $error("zero value not captured");

endmodule

FILE: src/rdsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_ctrl
// Sequencer for division, digit storage and most-significant-first readout.
// ----------------------------------------------------------------------------
module rdsc_ctrl
    import rdsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  rdsc_sts_t sts,
    output rdsc_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_RD,
        ST_LOAD,
        ST_ZERO
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;
    logic   accept;

    assign accept   = in_valid && !stall_reg;
    assign in_stall = stall_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        stall_next = stall_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    stall_next = 1'b1;
                    state_next = sts.in_zero ? ST_ZERO : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (sts.quot_zero || sts.cnt_full)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_digit = 1'b1;
                    if (sts.addr_zero)
                    begin
                        stall_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_ZERO:
            begin
                if (sts.out_free)
                begin
                    cmd.out_zero = 1'b1;
                    stall_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                stall_next = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

endmodule

FILE: src/rdsc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_dpath
// Configuration registers, bit-serial divider, digit store and output stage.
// ----------------------------------------------------------------------------
module rdsc_dpath
    import rdsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [63:0]           value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            char_out,
    output logic                  last_char,
    input  rdsc_cmd_t             cmd,
    output rdsc_sts_t             sts
);

    logic [RADIX_W-1:0]     radix_reg;
    logic [CFG_DATA_W-1:0]  alpha_lo_reg;
    logic [CFG_DATA_W-1:0]  alpha_hi_reg;

    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [COUNT_W-1:0]     digit_cnt_reg;
    logic [ADDR_W-1:0]      rd_addr_reg;
    logic [REM_W-1:0]       rd_data_reg;
    logic [REM_W-1:0]       digit_mem [STORE_DEPTH];

    logic                   out_valid_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;

    logic [VALUE_WIDTH-1:0] in_val;
    logic [TRIAL_W-1:0]     radix_eff;
    logic [TRIAL_W-1:0]     trial;
    logic                   qbit;
    logic [127:0]           alpha_all;
    logic [6:0]             alpha_sel;

    assign in_val = value[VALUE_WIDTH-1:0];

    // radix held within two and the largest supported base
    always_comb
    begin
        priority if (radix_reg < RADIX_W'(2))
        begin
            radix_eff = TRIAL_W'(2);
        end
        else if (radix_reg > RADIX_W'(MAX_RADIX))
        begin
            radix_eff = TRIAL_W'(MAX_RADIX);
        end
        else
        begin
            radix_eff = TRIAL_W'(radix_reg);
        end
    end

    // one restoring division step
    assign trial = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign qbit  = (trial >= radix_eff);

    // alphabet lookup, digit value selects a byte
    assign alpha_all = {alpha_hi_reg, alpha_lo_reg};
    assign alpha_sel = {rd_data_reg, 3'b000};

    // status to controller
    assign sts.in_zero   = (in_val == '0);
    assign sts.div_done  = (bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1));
    assign sts.quot_zero = (quot_reg == '0);
    assign sts.cnt_full  = (digit_cnt_reg == COUNT_W'(STORE_DEPTH - 1));
    assign sts.addr_zero = (rd_addr_reg == '0);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= RADIX_RST;
            alpha_lo_reg <= ALPHA_LO_RST;
            alpha_hi_reg <= ALPHA_HI_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RADIX)
            begin
                radix_reg <= cfg_data[RADIX_W-1:0];
            end
            if (cfg_index == CFG_ALPHA_LO)
            begin
                alpha_lo_reg <= cfg_data;
            end
            if (cfg_index == CFG_ALPHA_HI)
            begin
                alpha_hi_reg <= cfg_data;
            end
        end
    end

    // divider and digit counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg      <= '0;
            rem_reg       <= '0;
            bit_cnt_reg   <= '0;
            digit_cnt_reg <= '0;
            rd_addr_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                quot_reg      <= in_val;
                rem_reg       <= '0;
                bit_cnt_reg   <= '0;
                digit_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                quot_reg    <= {quot_reg[VALUE_WIDTH-2:0], qbit};
                rem_reg     <= qbit ? REM_W'(trial - radix_eff) : trial[REM_W-1:0];
                bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
            end
            if (cmd.store)
            begin
                digit_cnt_reg <= digit_cnt_reg + COUNT_W'(1);
                rd_addr_reg   <= digit_cnt_reg[ADDR_W-1:0];
                rem_reg       <= '0;
                bit_cnt_reg   <= '0;
            end
            if (cmd.out_digit)
            begin
                rd_addr_reg <= rd_addr_reg - ADDR_W'(1);
            end
        end
    end

    // digit store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            digit_mem[digit_cnt_reg[ADDR_W-1:0]] <= rem_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= digit_mem[rd_addr_reg];
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_digit || cmd.out_zero)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_digit)
        begin
            char_reg <= alpha_all[alpha_sel +: 8];
            last_reg <= sts.addr_zero;
        end
        else if (cmd.out_zero)
        begin
            char_reg <= ZERO_CHAR;
            last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last_char = last_reg;

endmodule
